// File: hw/rtl/dtd_pkg.sv
`timescale 1ns / 1ps
package dtd_pkg;

  localparam int TICK_WIDTH = 15;
  localparam int FULL_BITS  = 21;
  localparam int RUN_DIV_W  = ((TICK_WIDTH + 8 > 19) ? TICK_WIDTH + 8 : 19) + 1;
  localparam int ERPM_W     = 26;
  localparam int PERIOD_W   = 16;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_REPLY = 3'd1;
  localparam logic [2:0] ST_FRAMING  = 3'd2;
  localparam logic [2:0] ST_BAD_GCR  = 3'd3;
  localparam logic [2:0] ST_BAD_CRC  = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ERPM = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;
  localparam logic [1:0] KIND_EXT  = 2'd3;

  localparam logic CFG_BIT_PERIOD = 1'b0;
  localparam logic CFG_GAP_MIN    = 1'b1;

  localparam logic [ERPM_W-1:0] ERPM_NUM = 26'd60000000;

  typedef enum logic [1:0] {PH_SEEK, PH_DATA, PH_HOLD, PH_DRAIN} phase_t;
  typedef enum logic {F_IDLE, F_DIV} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_PAD, B_DEC, B_DIV, B_PUSH} back_state_t;

  typedef struct packed {
    logic                  pulse_level;
    logic [TICK_WIDTH-1:0] pulse_ticks;
    logic                  last_pulse;
  } pulse_t;

  typedef struct packed {
    logic [2:0]          rx_status;
    logic [7:0]          echo_pulses;
    logic [1:0]          payload_kind;
    logic [PERIOD_W-1:0] period_us;
    logic [ERPM_W-1:0]   erpm_value;
    logic [3:0]          ext_type;
    logic [7:0]          ext_value;
  } result_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           echo;
    logic [FULL_BITS-1:0] accum;
    logic [4:0]           count;
  } capture_t;

  // GCR quintet to nibble, bit 4 flags an invalid code
  function automatic logic [4:0] quintet_map(input logic [4:0] q);
    logic [4:0] r;
    case (q)
      5'h09: r = 5'h09;
      5'h0A: r = 5'h0A;
      5'h0B: r = 5'h0B;
      5'h0D: r = 5'h0D;
      5'h0E: r = 5'h0E;
      5'h0F: r = 5'h0F;
      5'h12: r = 5'h02;
      5'h13: r = 5'h03;
      5'h15: r = 5'h05;
      5'h16: r = 5'h06;
      5'h17: r = 5'h07;
      5'h19: r = 5'h00;
      5'h1A: r = 5'h08;
      5'h1B: r = 5'h01;
      5'h1D: r = 5'h04;
      5'h1E: r = 5'h0C;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/dtd_fifo.sv
`timescale 1ns / 1ps
module dtd_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  T           mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

// File: hw/rtl/dtd_divider.sv
`timescale 1ns / 1ps
module dtd_divider #(
  parameter int NW = 24,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  assign sh       = {rem, quo[NW-1]};
  assign diff     = sh - {1'b0, dvs};
  assign ge       = (sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/dtd_front.sv
`timescale 1ns / 1ps
module dtd_front import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  pulse_t      in_item,
  input  logic [19:0] bit_period_q8,
  input  logic [14:0] gap_min_ticks,
  output logic        cap_push,
  output capture_t    cap_rec,
  input  logic        cap_full
);
  front_state_t         fstate, fstate_next;
  phase_t               phase, phase_next;
  logic [FULL_BITS-1:0] accum, accum_next;
  logic [4:0]           count, count_next;
  logic [7:0]           echo, echo_next;
  logic                 pend_level;
  logic                 pend_last;

  logic                 accept;
  logic                 zero;
  logic [19:0]          q_eff;
  logic [RUN_DIV_W-1:0] run_dividend;
  logic                 div_start;
  logic                 div_done;
  logic [RUN_DIV_W-1:0] div_quot;
  logic [4:0]           avail;
  logic [4:0]           n;
  logic [7:0]           echo_inc;
  logic                 fin;
  logic                 fin_zero;
  logic [2:0]           fin_status;

  assign full         = (fstate != F_IDLE) || cap_full;
  assign accept       = push && !full;
  assign zero         = (in_item.pulse_ticks == '0);
  assign q_eff        = (bit_period_q8 == '0) ? 20'd1 : bit_period_q8;
  assign run_dividend = RUN_DIV_W'({in_item.pulse_ticks, 8'h00}) + RUN_DIV_W'(q_eff >> 1);
  assign avail        = 5'(FULL_BITS) - count;
  assign echo_inc     = (echo == 8'hFF) ? echo : echo + 8'd1;

  always_comb begin
    if (div_quot == '0) begin
      n = 5'd1;
    end else if (div_quot > RUN_DIV_W'(avail)) begin
      n = avail;
    end else begin
      n = div_quot[4:0];
    end
  end

  dtd_divider #(.NW(RUN_DIV_W), .DW(20)) u_run_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (run_dividend),
    .divisor  (q_eff),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_level <= in_item.pulse_level;
      pend_last  <= in_item.last_pulse;
    end
    if (rst) begin
      fstate <= F_IDLE;
      phase  <= PH_SEEK;
      accum  <= '0;
      count  <= '0;
      echo   <= '0;
    end else begin
      fstate <= fstate_next;
      phase  <= phase_next;
      accum  <= accum_next;
      count  <= count_next;
      echo   <= echo_next;
    end
  end

  always_comb begin
    fstate_next = fstate;
    phase_next  = phase;
    accum_next  = accum;
    count_next  = count;
    echo_next   = echo;
    div_start   = 1'b0;
    fin         = 1'b0;
    fin_zero    = 1'b0;
    fin_status  = ST_OK;
    cap_push    = 1'b0;
    cap_rec     = '0;
    case (fstate)
      F_IDLE: begin
        if (accept) begin
          case (phase)
            PH_SEEK: begin
              if (zero) begin
                fin        = 1'b1;
                fin_zero   = 1'b1;
                fin_status = ST_NO_REPLY;
              end else if (in_item.pulse_level &&
                           in_item.pulse_ticks >= gap_min_ticks) begin
                phase_next = PH_DATA;
                fin        = in_item.last_pulse;
                fin_status = ST_NO_REPLY;
              end else begin
                echo_next  = echo_inc;
                fin        = in_item.last_pulse;
                fin_status = ST_NO_REPLY;
              end
            end
            PH_DATA: begin
              if (zero) begin
                fin      = 1'b1;
                fin_zero = 1'b1;
              end else if (count < 5'(FULL_BITS)) begin
                if (count == '0 && in_item.pulse_level) begin
                  phase_next = PH_HOLD;
                  fin        = in_item.last_pulse;
                  fin_status = ST_FRAMING;
                end else begin
                  div_start   = 1'b1;
                  fstate_next = F_DIV;
                end
              end else begin
                fin = in_item.last_pulse;
              end
            end
            PH_HOLD: begin
              fin        = zero || in_item.last_pulse;
              fin_zero   = zero;
              fin_status = ST_FRAMING;
            end
            PH_DRAIN: begin
              if (in_item.last_pulse) begin
                phase_next = PH_SEEK;
              end
            end
            default: phase_next = PH_SEEK;
          endcase
        end
      end
      F_DIV: begin
        if (div_done) begin
          accum_next  = (accum << n) |
                        (pend_level ? '0 : ~({FULL_BITS{1'b1}} << n));
          count_next  = count + n;
          fstate_next = F_IDLE;
          fin         = pend_last;
        end
      end
      default: fstate_next = F_IDLE;
    endcase

    if (fin) begin
      cap_push       = 1'b1;
      cap_rec.status = fin_status;
      cap_rec.echo   = echo_next;
      cap_rec.accum  = accum_next;
      cap_rec.count  = count_next;
      phase_next     = (fin_zero && !in_item.last_pulse) ? PH_DRAIN : PH_SEEK;
      accum_next     = '0;
      count_next     = '0;
      echo_next      = '0;
    end
  end
endmodule

// File: hw/rtl/dtd_back.sv
`timescale 1ns / 1ps
module dtd_back import dtd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cap_empty,
  output logic     cap_pop,
  input  capture_t cap_rec,
  output logic     res_push,
  output result_t  res,
  input  logic     res_full
);
  back_state_t          state, state_next;
  capture_t             rec;
  logic [FULL_BITS-1:0] v;
  logic [19:0]          gcr;
  logic [4:0]           q3, q2, q1, q0;
  logic                 bad_gcr;
  logic [15:0]          d16;
  logic [3:0]           crc;
  logic [11:0]          d12;
  logic [PERIOD_W-1:0]  per;
  result_t              dec;
  logic                 div_start;
  logic                 div_done;
  logic [ERPM_W-1:0]    div_quot;

  assign gcr     = v[19:0] ^ v[20:1];
  assign q3      = quintet_map(gcr[19:15]);
  assign q2      = quintet_map(gcr[14:10]);
  assign q1      = quintet_map(gcr[9:5]);
  assign q0      = quintet_map(gcr[4:0]);
  assign bad_gcr = q3[4] | q2[4] | q1[4] | q0[4];
  assign d16     = {q3[3:0], q2[3:0], q1[3:0], q0[3:0]};
  assign crc     = d16[3:0] ^ d16[7:4] ^ d16[11:8] ^ d16[15:12];
  assign d12     = d16[15:4];
  assign per     = PERIOD_W'({7'd0, d12[8:0]} << d12[11:9]);

  always_comb begin
    dec             = '0;
    dec.echo_pulses = rec.echo;
    if (rec.status != ST_OK) begin
      dec.rx_status = rec.status;
    end else if (rec.count == '0) begin
      dec.rx_status = ST_NO_REPLY;
    end else if (bad_gcr) begin
      dec.rx_status = ST_BAD_GCR;
    end else if (crc != 4'hF) begin
      dec.rx_status = ST_BAD_CRC;
    end else begin
      dec.rx_status = ST_OK;
      if (d12[11:8] != 4'd0 && !d12[8]) begin
        dec.payload_kind = KIND_EXT;
        dec.ext_type     = d12[11:8];
        dec.ext_value    = d12[7:0];
      end else if (d12 == 12'hFFF) begin
        dec.payload_kind = KIND_STOP;
      end else begin
        dec.payload_kind = KIND_ERPM;
        dec.period_us    = per;
      end
    end
  end

  dtd_divider #(.NW(ERPM_W), .DW(PERIOD_W)) u_erpm_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ERPM_NUM),
    .divisor  (res.period_us),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cap_pop) begin
      rec <= cap_rec;
    end
    if (state == B_PAD) begin
      v <= (rec.count == '0) ? '0 : FULL_BITS'(rec.accum << (5'(FULL_BITS) - rec.count));
    end
    if (state == B_DEC) begin
      res <= dec;
    end
    if (state == B_DIV && div_done) begin
      res.erpm_value <= div_quot;
    end
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cap_pop    = 1'b0;
    div_start  = 1'b0;
    res_push   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!cap_empty) begin
          cap_pop    = 1'b1;
          state_next = B_PAD;
        end
      end
      B_PAD: state_next = B_DEC;
      B_DEC: begin
        state_next = B_PUSH;
      end
      B_PUSH: begin
        if (res.payload_kind == KIND_ERPM && res.period_us != '0 &&
            res.erpm_value == '0) begin
          div_start  = 1'b1;
          state_next = B_DIV;
        end else if (!res_full) begin
          res_push   = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_PUSH;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/dshot_telemetry_decoder.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// pulses    in         push / full          in_item  (pulse_t)
// results   out        pop / empty          out_item (result_t)
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A pulse that is not a data run needs no division; a data run holds full high
// while the bit-serial run-length divider in the front end works.
// Each capture then passes through the back end (pad, GCR/CRC decode and, for
// eRPM frames, a 26-step serial eRPM divider), overlapped with the next capture.
// Reset is synchronous and immediate: no clearing pass.
// Two-entry queues between front and back and at the output absorb stalls.
module dshot_telemetry_decoder import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  pulse_t      in_item,
  output logic        empty,
  input  logic        pop,
  output result_t     out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);
  logic [19:0] bit_period_q8;
  logic [14:0] gap_min_ticks;
  logic        cap_push, cap_full, cap_pop, cap_empty;
  capture_t    cap_wr, cap_rd;
  logic        res_push, res_full;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_q8 <= 20'd27306;
      gap_min_ticks <= 15'd332;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIT_PERIOD: bit_period_q8 <= cfg_data;
        CFG_GAP_MIN:    gap_min_ticks <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  dtd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .bit_period_q8 (bit_period_q8),
    .gap_min_ticks (gap_min_ticks),
    .cap_push      (cap_push),
    .cap_rec       (cap_wr),
    .cap_full      (cap_full)
  );

  dtd_fifo #(.T(capture_t)) u_cap_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cap_push),
    .wdata (cap_wr),
    .full  (cap_full),
    .pop   (cap_pop),
    .rdata (cap_rd),
    .empty (cap_empty)
  );

  dtd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cap_empty (cap_empty),
    .cap_pop   (cap_pop),
    .cap_rec   (cap_rd),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  dtd_fifo #(.T(result_t)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );
endmodule

// File: hw/rtl/dtd_checker.sv
`timescale 1ns / 1ps
module dtd_checker import dtd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input result_t out_item
);
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.rx_status <= ST_BAD_CRC)
    else $error("status code out of range");

  a_error_no_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.rx_status != ST_OK) |->
      (out_item.payload_kind == KIND_NONE && out_item.period_us == '0 &&
       out_item.erpm_value == '0))
    else $error("payload on failed frame");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.payload_kind == KIND_STOP) |->
      (out_item.period_us == '0 && out_item.erpm_value == '0))
    else $error("stopped frame carries period");

  a_ext_type: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.payload_kind == KIND_EXT) |->
      (out_item.ext_type != 4'd0 && !out_item.ext_type[0]))
    else $error("bad extended type");
endmodule

bind dshot_telemetry_decoder dtd_checker u_dtd_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import dtd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  pulse_t      in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;

  dshot_telemetry_decoder u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // decoder model state
  logic [19:0] m_period_q8;
  logic [14:0] m_gap_min;
  phase_t      m_phase;
  logic [20:0] m_accum;
  logic [4:0]  m_count;
  logic [7:0]  m_echo;

  result_t telemetry_q[$];
  int errors = 0;
  int pulses_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_cnt = 0;

  // quintet -> nibble, 16 marks an illegal code
  int qdec[32] = '{16, 16, 16, 16, 16, 16, 16, 16, 16, 9, 10, 11, 16, 13, 14, 15,
                   16, 16, 2, 3, 16, 5, 6, 7, 16, 0, 8, 1, 16, 4, 12, 16};
  logic [4:0] qenc[16] = '{5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
                           5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F};

  function automatic result_t decode_capture(logic [2:0] st);
    result_t    r;
    logic [20:0] v;
    logic [19:0] g;
    int          nib [4];
    logic [15:0] d16;
    logic [7:0]  cs;
    logic [11:0] d12;
    logic [31:0] per;
    r = '0;
    r.echo_pulses = m_echo;
    if (st == ST_OK && m_count == 0) st = ST_NO_REPLY;
    if (st == ST_OK) begin
      v = m_accum << (FULL_BITS - m_count);
      g = v[19:0] ^ v[20:1];
      for (int i = 0; i < 4; i++) nib[i] = qdec[g[i*5 +: 5]];
      if (nib[0] > 15 || nib[1] > 15 || nib[2] > 15 || nib[3] > 15) begin
        st = ST_BAD_GCR;
      end else begin
        d16 = {nib[3][3:0], nib[2][3:0], nib[1][3:0], nib[0][3:0]};
        cs = d16[7:0] ^ d16[15:8];
        if ((cs[3:0] ^ cs[7:4]) != 4'hF) begin
          st = ST_BAD_CRC;
        end else begin
          d12 = d16[15:4];
          if (d12[11:8] != 0 && !d12[8]) begin
            r.payload_kind = KIND_EXT;
            r.ext_type = d12[11:8];
            r.ext_value = d12[7:0];
          end else if (d12 == 12'hFFF) begin
            r.payload_kind = KIND_STOP;
          end else begin
            per = {23'd0, d12[8:0]} << d12[11:9];
            r.payload_kind = KIND_ERPM;
            r.period_us = per[15:0];
            r.erpm_value = (per != 0) ? 26'(60000000 / per) : '0;
          end
        end
      end
    end
    r.rx_status = st;
    return r;
  endfunction

  function automatic void clear_capture();
    m_phase = PH_SEEK;
    m_accum = '0;
    m_count = '0;
    m_echo = '0;
  endfunction

  function automatic bit predict_pulse(pulse_t p, output result_t r);
    logic [31:0] q;
    logic [31:0] n;
    bit          z;
    bit          fin;
    bit          drain;
    logic [2:0]  st;
    z = (p.pulse_ticks == 0);
    fin = 1'b0;
    drain = 1'b0;
    st = ST_OK;
    r = '0;
    case (m_phase)
      PH_SEEK: begin
        if (z) begin
          fin = 1; st = ST_NO_REPLY; drain = !p.last_pulse;
        end else begin
          if (p.pulse_level && p.pulse_ticks >= m_gap_min) m_phase = PH_DATA;
          else if (m_echo != 8'hFF) m_echo++;
          if (p.last_pulse) begin
            fin = 1; st = ST_NO_REPLY;
          end
        end
      end
      PH_DATA: begin
        if (z) begin
          fin = 1; drain = !p.last_pulse;
        end else if (m_count == 0 && p.pulse_level) begin
          m_phase = PH_HOLD;
          if (p.last_pulse) begin
            fin = 1; st = ST_FRAMING;
          end
        end else begin
          if (m_count < FULL_BITS) begin
            q = (m_period_q8 == 0) ? 32'd1 : {12'd0, m_period_q8};
            n = ({17'd0, p.pulse_ticks} * 256 + (q >> 1)) / q;
            if (n == 0) n = 1;
            if (n > FULL_BITS - m_count) n = FULL_BITS - m_count;
            m_accum = (m_accum << n) | (p.pulse_level ? 21'd0 : 21'((64'd1 << n) - 1));
            m_count = m_count + 5'(n);
          end
          if (p.last_pulse) fin = 1;
        end
      end
      PH_HOLD: begin
        if (z || p.last_pulse) begin
          fin = 1; st = ST_FRAMING; drain = z && !p.last_pulse;
        end
      end
      default: if (p.last_pulse) clear_capture();
    endcase
    if (fin) begin
      r = decode_capture(st);
      clear_capture();
      if (drain) m_phase = PH_DRAIN;
    end
    return fin;
  endfunction

  task automatic send_pulse(pulse_t p, bit typed = 0, result_t typed_res = '0);
    bit      acc;
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= p;
    do begin
      @(negedge clk);
      acc = !full;
      @(posedge clk);
    end while (!acc);
    pulses_sent++;
    if (predict_pulse(p, r)) telemetry_q.push_back(typed ? typed_res : r);
  endtask

  task automatic cfg_write(logic idx, logic [19:0] val);
    bit acc;
    push <= 1'b0;
    wait (telemetry_q.size() == 0);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    if (idx == CFG_BIT_PERIOD) m_period_q8 = val;
    else m_gap_min = val[14:0];
  endtask

  function automatic pulse_t mk(logic lvl, int ticks, logic lst);
    pulse_t p;
    p.pulse_level = lvl;
    p.pulse_ticks = ticks[14:0];
    p.last_pulse = lst;
    return p;
  endfunction

  // echo, gap, GCR runs, then one of three ways to close the capture
  task automatic send_frame(logic [11:0] d12, bit bad_crc, int echo_n, int end_mode);
    logic [15:0] d16;
    logic [19:0] g;
    logic [20:0] v;
    int          run_len [$];
    logic        run_lvl [$];
    int          n;
    int          t;
    int          cnt;
    d16 = {d12, ~(d12[11:8] ^ d12[7:4] ^ d12[3:0])};
    if (bad_crc) d16[$urandom_range(3)] ^= 1'b1;
    for (int i = 0; i < 4; i++) g[i*5 +: 5] = qenc[d16[i*4 +: 4]];
    v[20] = 1'b1;
    for (int i = 19; i >= 0; i--) v[i] = v[i+1] ^ g[i];
    cnt = 1;
    for (int i = 19; i >= -1; i--) begin
      if (i >= 0 && v[i] == v[i+1]) begin
        cnt++;
      end else begin
        run_len.push_back(cnt);
        run_lvl.push_back(!v[i+1]);
        cnt = 1;
      end
    end
    if (run_lvl[$] && $urandom_range(1)) begin
      void'(run_len.pop_back());
      void'(run_lvl.pop_back());
    end
    for (int i = 0; i < echo_n; i++) begin
      if (m_gap_min > 1 && $urandom_range(1))
        send_pulse(mk(1'b1, $urandom_range(1, m_gap_min - 1), 1'b0));
      else
        send_pulse(mk(1'b0, $urandom_range(1, 400), 1'b0));
    end
    send_pulse(mk(1'b1, $urandom_range(m_gap_min, 32767), 1'b0));
    n = run_len.size();
    for (int i = 0; i < n; i++) begin
      t = (run_len[i] * m_period_q8 + 128) >> 8;
      if (t < 1) t = 1;
      if (t > 32767) t = 32767;
      send_pulse(mk(run_lvl[i], t, (end_mode == 0 && i == n - 1)));
    end
    if (end_mode == 1) send_pulse(mk($urandom_range(1), 0, 1'b1));
    if (end_mode == 2) begin
      send_pulse(mk($urandom_range(1), 0, 1'b0));
      repeat ($urandom_range(0, 3)) send_pulse(mk($urandom_range(1), $urandom_range(32767), 0));
      send_pulse(mk($urandom_range(1), $urandom_range(32767), 1'b1));
    end
  endtask

  task automatic send_noise();
    int k;
    k = $urandom_range(1, 8);
    for (int i = 0; i < k; i++)
      send_pulse(mk($urandom_range(1), ($urandom_range(9) == 0) ? 0 : $urandom_range(32767),
                    (i == k - 1) || ($urandom_range(15) == 0)));
  endtask

  task automatic cmp_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    result_t e;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (telemetry_q.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_item);
        errors++;
      end else begin
        e = telemetry_q.pop_front();
        cmp_field("rx_status", e.rx_status, out_item.rx_status);
        cmp_field("echo_pulses", e.echo_pulses, out_item.echo_pulses);
        cmp_field("payload_kind", e.payload_kind, out_item.payload_kind);
        cmp_field("period_us", e.period_us, out_item.period_us);
        cmp_field("erpm_value", e.erpm_value, out_item.erpm_value);
        cmp_field("ext_type", e.ext_type, out_item.ext_type);
        cmp_field("ext_value", e.ext_value, out_item.ext_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      hold_cnt <= 2000;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  typedef struct {
    pulse_t  p;
    bit      typed;
    result_t e;
  } pulse_row_t;

  function automatic result_t rs(logic [2:0] st, logic [7:0] echo);
    result_t r;
    r = '0;
    r.rx_status = st;
    r.echo_pulses = echo;
    return r;
  endfunction

  initial begin
    pulse_row_t  rows [$];
    logic [19:0] periods [5];
    logic [14:0] gaps [5];
    int          idle_mode [4][2];
    int          target;
    m_period_q8 = 20'd27306;
    m_gap_min = 15'd332;
    clear_capture();
    periods = '{20'd27306, 20'd1, 20'd1048575, 20'd256, 20'd4000};
    gaps = '{15'd332, 15'd1, 15'd32767, 15'd20, 15'd150};
    idle_mode = '{'{0, 0}, '{84, 0}, '{0, 84}, '{23, 23}};
    rows = '{
      '{mk(0, 0, 0), 1, rs(ST_NO_REPLY, 0)},
      '{mk(1, 32767, 1), 0, '0},
      '{mk(0, 32767, 1), 1, rs(ST_NO_REPLY, 1)},
      '{mk(1, 400, 0), 0, '0},
      '{mk(1, 100, 1), 1, rs(ST_FRAMING, 0)},
      '{mk(1, 332, 0), 0, '0},
      '{mk(0, 107, 0), 0, '0},
      '{mk(0, 0, 1), 0, '0},
      '{mk(1, 32767, 0), 0, '0},
      '{mk(0, 32767, 0), 0, '0},
      '{mk(1, 5, 0), 0, '0},
      '{mk(0, 0, 1), 1, rs(ST_BAD_GCR, 0)},
      '{mk(1, 332, 0), 0, '0},
      '{mk(1, 200, 0), 0, '0},
      '{mk(0, 50, 0), 0, '0},
      '{mk(0, 0, 0), 1, rs(ST_FRAMING, 0)},
      '{mk(0, 10, 1), 0, '0},
      '{mk(1, 1000, 1), 1, rs(ST_NO_REPLY, 0)},
      '{mk(1, 500, 0), 0, '0},
      '{mk(0, 0, 1), 1, rs(ST_NO_REPLY, 0)}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_pulse(rows[i].p, rows[i].typed, rows[i].e);
    send_frame(12'hFFF, 0, 3, 0);
    send_frame(12'h2AB, 0, 0, 1);
    send_frame(12'h000, 0, 1, 2);
    send_frame(12'hFFF, 0, 2, 0);
    send_frame(12'h123, 1, 0, 0);
    periods[4] = $urandom_range(20'h200, 20'h8000);
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_BIT_PERIOD, periods[ph]);
      cfg_write(CFG_GAP_MIN, 20'(gaps[ph]));
      send_idle_pct = idle_mode[ph % 4][0];
      recv_stall_pct = idle_mode[ph % 4][1];
      target = pulses_sent + 250;
      while (pulses_sent < target) begin
        if (ph == 1 && pulses_sent + 150 > target && hold_reqs == 0) hold_reqs = 1;
        if ($urandom_range(99) < 85)
          send_frame($urandom_range(12'hFFF), $urandom_range(9) == 0,
                     ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(4),
                     $urandom_range(2));
        else
          send_noise();
      end
    end
    push <= 1'b0;
    wait (telemetry_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d pulses sent, %0d telemetry results checked over 5 timing setups",
             pulses_sent, results_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off");
    if (errors == 0 && telemetry_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_fifo.sv
hw/rtl/dtd_divider.sv
hw/rtl/dtd_front.sv
hw/rtl/dtd_back.sv
hw/rtl/dshot_telemetry_decoder.sv
hw/rtl/dtd_checker.sv
test/testbench.sv
